### rtl/tgr_pkg.sv
package tgr_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned StateW = 3;
  localparam int unsigned AddrW  = 2;

  // stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // gesture state codes
  localparam logic [StateW-1:0] StIdle     = 3'd0;
  localparam logic [StateW-1:0] StWaitRel1 = 3'd1;
  localparam logic [StateW-1:0] StWaitTap2 = 3'd2;
  localparam logic [StateW-1:0] StWaitRel2 = 3'd3;
  localparam logic [StateW-1:0] StHeld     = 3'd4;

  // configuration register indexes
  localparam logic [AddrW-1:0] RegDebounce  = 2'd0;
  localparam logic [AddrW-1:0] RegLongPress = 2'd1;
  localparam logic [AddrW-1:0] RegDblWindow = 2'd2;

  // item operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  typedef struct packed {
    logic             op;
    logic             touched;
    logic [TimeW-1:0] now_ms;
  } tgr_sample_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_tap_window_ms;
  } tgr_cfg_t;

  typedef struct packed {
    logic long_press;
    logic double_tap;
    logic single_tap;
  } tgr_flags_t;

endpackage

### rtl/tgr_fsm.sv
module tgr_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tgr_pkg::tgr_sample_t sample_i,
  input  tgr_pkg::tgr_cfg_t    cfg_i,
  output tgr_pkg::tgr_flags_t  flags_o
);
  import tgr_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic [TimeW-1:0]  last_tap_q, last_tap_d;
  logic [TimeW-1:0]  since_tap, since_press;
  logic              touched;
  tgr_flags_t        flags;

  // modular elapsed times
  assign since_tap   = sample_i.now_ms - last_tap_q;
  assign since_press = sample_i.now_ms - press_start_q;
  assign touched     = sample_i.touched;

  // next state and flags for the current sample
  always_comb begin
    state_d       = state_q;
    press_start_d = press_start_q;
    last_tap_d    = last_tap_q;
    flags         = '0;
    if (sample_i.op == OpClear) begin
      state_d = StIdle;
    end else begin
      unique case (state_q)
        StWaitRel1: begin
          if (!touched && since_tap > {16'd0, cfg_i.debounce_ms}) begin
            last_tap_d = sample_i.now_ms;
            state_d    = StWaitTap2;
          end else if (touched && since_press >= {16'd0, cfg_i.long_press_ms}) begin
            flags.long_press = 1'b1;
            state_d          = StHeld;
          end
        end
        StWaitTap2: begin
          if (touched) begin
            last_tap_d = sample_i.now_ms;
            state_d    = StWaitRel2;
          end else if (since_tap >= {16'd0, cfg_i.double_tap_window_ms}) begin
            flags.single_tap = 1'b1;
            state_d          = StIdle;
          end
        end
        StWaitRel2: begin
          if (!touched && since_tap > {16'd0, cfg_i.debounce_ms}) begin
            flags.double_tap = 1'b1;
            state_d          = StIdle;
          end else if (touched && since_tap > {16'd0, cfg_i.double_tap_window_ms}) begin
            state_d = StIdle;
          end
        end
        StHeld: begin
          if (!touched) begin
            state_d = StIdle;
          end
        end
        default: begin
          // idle and unreachable codes
          if (touched) begin
            press_start_d = sample_i.now_ms;
            last_tap_d    = sample_i.now_ms;
            state_d       = StWaitRel1;
          end else begin
            state_d = StIdle;
          end
        end
      endcase
    end
  end

  assign flags_o = flags;

  // gesture state and stored times
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      press_start_q <= '0;
      last_tap_q    <= '0;
    end else if (step_i) begin
      state_q       <= state_d;
      press_start_q <= press_start_d;
      last_tap_q    <= last_tap_d;
    end
  end

`ifndef SYNTHESIS
  a_flags_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> $onehot0(flags))
    else $error("more than one gesture flag on one sample");

  a_clear_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && sample_i.op == OpClear) |=> (state_q == StIdle))
    else $error("clear did not return to idle");

  a_long_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && flags.long_press) |=> (state_q == StHeld))
    else $error("long press without entering held");

  a_dbl_from_rel2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && flags.double_tap) |-> (state_q == StWaitRel2 && !touched))
    else $error("double tap outside second release");
`endif

endmodule

### rtl/tap_gesture_recognizer.sv
// Tap gesture recognizer: one touch sample per input beat (tuser = clear
// command, tdata = touched and a wrapping millisecond timestamp), one output
// beat per input beat carrying the single tap, double tap and long press
// flags for that sample. A new sample is taken every clock cycle, except
// when back-pressure on the output stalls the input once both registers
// are full; the sample sits in the input register and the state update
// writes its flags into the output register once it is empty or being read.
// The user must write thresholds through the cfg port only while no beat
// is in flight; the block itself does not enforce this.
module tap_gesture_recognizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [tgr_pkg::AddrW-1:0]    cfg_addr_i,
  input  logic [tgr_pkg::CfgW-1:0]     cfg_wdata_i,
  // sample stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tgr_pkg::InDataW-1:0]  s_axis_tdata,   // touched, now_ms[31:0], zero pad
  input  logic                         s_axis_tuser,   // op
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tgr_pkg::OutDataW-1:0] m_axis_tdata    // single_tap, double_tap, long_press, zero pad
);
  import tgr_pkg::*;

  tgr_cfg_t    cfg_q;
  logic        in_vld_q;
  tgr_sample_t in_smp_q;
  logic        out_vld_q;
  tgr_flags_t  out_flags_q;
  tgr_flags_t  flags;
  logic        s_fire;
  logic        adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms          <= 16'd50;
      cfg_q.long_press_ms        <= 16'd800;
      cfg_q.double_tap_window_ms <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegDebounce:  cfg_q.debounce_ms          <= cfg_wdata_i;
        RegLongPress: cfg_q.long_press_ms        <= cfg_wdata_i;
        RegDblWindow: cfg_q.double_tap_window_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_smp_q.op      <= s_axis_tuser;
      in_smp_q.touched <= s_axis_tdata[0];
      in_smp_q.now_ms  <= s_axis_tdata[TimeW:1];
    end
  end

  tgr_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .sample_i (in_smp_q),
    .cfg_i    (cfg_q),
    .flags_o  (flags)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_flags_q.long_press, out_flags_q.double_tap,
                          out_flags_q.single_tap};

endmodule
